// ===== rtl/tmcd_pkg.sv =====
// shared types, codes and helpers of the tlv motion command decoder
// no dependencies; imported by tmcd_parser and tlv_motion_command_decoder
package tmcd_pkg;

    // stream widths
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 120;   // 113 bits of fields, padded to bytes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned LIMIT_W    = 31;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned TICK_W     = 17;

    // item kinds carried on tuser
    localparam logic [IN_USER_W-1:0] OP_BYTE      = 2'd0;
    localparam logic [IN_USER_W-1:0] OP_TICK      = 2'd1;
    localparam logic [IN_USER_W-1:0] OP_EMPTY_END = 2'd2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINEAR_LIMIT  = 2'd0,
        REG_ANGULAR_LIMIT = 2'd1,
        REG_LIFT_LIMIT    = 2'd2,
        REG_LINK_TIMEOUT  = 2'd3
    } t_reg_idx;

    // reset values of the registers
    localparam logic [LIMIT_W-1:0]   LINEAR_LIMIT_RST  = 31'd500;
    localparam logic [LIMIT_W-1:0]   ANGULAR_LIMIT_RST = 31'd400;
    localparam logic [LIMIT_W-1:0]   LIFT_LIMIT_RST    = 31'd250;
    localparam logic [TIMEOUT_W-1:0] LINK_TIMEOUT_RST  = 16'd2000;

    // record tags and value lengths
    localparam logic [7:0] TAG_LINEAR  = 8'd1;
    localparam logic [7:0] TAG_ANGULAR = 8'd2;
    localparam logic [7:0] TAG_LIFT    = 8'd3;
    localparam logic [7:0] TAG_MASK    = 8'd4;
    localparam logic [7:0] TAG_STATUS  = 8'd5;
    localparam logic [7:0] LEN_WORD    = 8'd4;
    localparam logic [7:0] LEN_HALF    = 8'd2;

    // found flag positions
    localparam int unsigned F_LINEAR  = 0;
    localparam int unsigned F_ANGULAR = 1;
    localparam int unsigned F_LIFT    = 2;
    localparam int unsigned F_MASK    = 3;
    localparam int unsigned F_STATUS  = 4;

    // values collected so far in the current frame
    typedef struct packed {
        logic [4:0]  found;
        logic [31:0] linear;
        logic [31:0] angular;
        logic [31:0] lift;
        logic [15:0] mask;
        logic [15:0] status;
    } t_pending;

    // symmetric clamp of a signed 32-bit value to [-lim, +lim]
    function automatic logic [31:0] clamp_sym(logic [31:0] x, logic [LIMIT_W-1:0] lim);
        logic signed [32:0] v;
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        v  = {x[31], x};
        hi = {2'b00, lim};
        lo = -hi;
        if (v > hi) begin
            return hi[31:0];
        end else if (v < lo) begin
            return lo[31:0];
        end
        return x;
    endfunction

endpackage

// ===== rtl/tlv_motion_command_decoder.sv =====
// top level of the tlv motion command decoder: commit, clamp, link timer, output word
// depends on tmcd_pkg and tmcd_parser
//
// usage
//   slave stream: one word per item; tuser is the item kind (payload byte,
//   time tick, end of empty frame), tdata the payload byte, tlast marks the
//   final payload byte of a frame
//   master stream: one word per accepted item with the committed linear,
//   angular and lift commands, the status word and the link-alive flag;
//   tlast is high when that item ended a frame and committed it
//   config channel: write-only, index selects the limit or timeout register,
//   writes are taken every cycle and are meant to land while the block is idle
//   result: registered, appears in the cycle after the input word is accepted
//   throughput: one word per cycle while the master side takes its words;
//   each item is parsed, committed and clamped combinationally between the
//   input handshake and the result register
//   stall: a full result register blocks the slave side until the word is
//   taken; the slave is ready in the same cycle the master word leaves
//   reset: synchronous active low; clears the parser, the committed values,
//   the link timer and the result valid, and restores register defaults
module tlv_motion_command_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [tmcd_pkg::IN_DATA_W-1:0]     i_s_tdata,   // [7:0] data_byte
    input  logic [tmcd_pkg::IN_USER_W-1:0]     i_s_tuser,   // [1:0] op
    input  logic                               i_s_tlast,   // last
    // master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [31:0] linear_speed, [63:32] angular_speed, [95:64] lift_position,
    // [111:96] status bits, [112] link_alive, [119:113] zero
    output logic [tmcd_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast,   // frame_done
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tmcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tmcd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tmcd_pkg::*;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // configuration registers
    logic [LIMIT_W-1:0]   r_linear_limit;
    logic [LIMIT_W-1:0]   r_angular_limit;
    logic [LIMIT_W-1:0]   r_lift_limit;
    logic [TIMEOUT_W-1:0] r_link_timeout;

    // committed state
    logic [31:0]       r_held_linear, n_held_linear;
    logic [31:0]       r_held_angular, n_held_angular;
    logic [31:0]       r_held_lift, n_held_lift;
    logic [15:0]       r_held_status, n_held_status;
    logic              r_link_seen, n_link_seen;
    logic [TICK_W-1:0] r_ticks, n_ticks;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  r_out_last;

    logic     accept;
    logic     byte_en;
    logic     tick;
    logic     frame_end;
    logic     alive;
    t_pending pend;

    // a word is taken whenever the result register is empty or drains now
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;
    assign byte_en     = accept && (i_s_tuser == OP_BYTE);
    assign tick        = accept && (i_s_tuser == OP_TICK);
    assign frame_end   = accept && (((i_s_tuser == OP_BYTE) && i_s_tlast) ||
                                    (i_s_tuser == OP_EMPTY_END));
    assign o_cfg_ready = 1'b1;

    tmcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_en   (byte_en),
        .i_byte      (i_s_tdata),
        .i_frame_end (frame_end),
        .o_pend      (pend)
    );

    // commit at frame end, and the link timer
    always_comb begin
        n_held_linear  = r_held_linear;
        n_held_angular = r_held_angular;
        n_held_lift    = r_held_lift;
        n_held_status  = r_held_status;
        n_link_seen    = r_link_seen;
        n_ticks        = r_ticks;
        if (frame_end) begin
            if (pend.found[F_LINEAR]) begin
                n_held_linear = clamp_sym(pend.linear, r_linear_limit);
            end
            if (pend.found[F_ANGULAR]) begin
                n_held_angular = clamp_sym(pend.angular, r_angular_limit);
            end
            if (pend.found[F_LIFT]) begin
                n_held_lift = clamp_sym(pend.lift, r_lift_limit);
            end
            // masked status update needs both halves of the pair
            if (pend.found[F_MASK] && pend.found[F_STATUS]) begin
                n_held_status = (r_held_status & ~pend.mask) | (pend.status & pend.mask);
            end
            n_link_seen = 1'b1;
            n_ticks     = '0;
        end else if (tick && (r_ticks != TICK_MAX)) begin
            n_ticks = r_ticks + 1'b1;
        end
        alive      = n_link_seen && (n_ticks <= {1'b0, r_link_timeout});
        n_out_data = {7'd0, alive, n_held_status, n_held_lift, n_held_angular, n_held_linear};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_linear  <= '0;
            r_held_angular <= '0;
            r_held_lift    <= '0;
            r_held_status  <= '0;
            r_link_seen    <= 1'b0;
            r_ticks        <= '0;
        end else begin
            r_held_linear  <= n_held_linear;
            r_held_angular <= n_held_angular;
            r_held_lift    <= n_held_lift;
            r_held_status  <= n_held_status;
            r_link_seen    <= n_link_seen;
            r_ticks        <= n_ticks;
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_limit  <= LINEAR_LIMIT_RST;
            r_angular_limit <= ANGULAR_LIMIT_RST;
            r_lift_limit    <= LIFT_LIMIT_RST;
            r_link_timeout  <= LINK_TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LINEAR_LIMIT:  r_linear_limit  <= i_cfg_data[LIMIT_W-1:0];
                REG_ANGULAR_LIMIT: r_angular_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_LIFT_LIMIT:    r_lift_limit    <= i_cfg_data[LIMIT_W-1:0];
                REG_LINK_TIMEOUT:  r_link_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // result register: valid cleared by reset, word and frame flag load on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
            r_out_last <= frame_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/tmcd_parser.sv =====
// tag-length-value record parser: assembles values and tracks found records
// depends on tmcd_pkg
module tmcd_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_en,
    input  logic [7:0]            i_byte,
    input  logic                  i_frame_end,
    output tmcd_pkg::t_pending    o_pend      // values including the current byte
);
    import tmcd_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG = 3'b001,
        PH_LEN = 3'b010,
        PH_VAL = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_shift, n_shift;
    t_pending    r_pend, n_pend;
    logic        finish;
    logic [7:0]  idx;

    always_comb begin
        n_phase = r_phase;
        n_tag   = r_tag;
        n_len   = r_len;
        n_left  = r_left;
        n_shift = r_shift;
        n_pend  = r_pend;
        finish  = 1'b0;
        idx     = r_len - r_left;
        if (i_byte_en) begin
            unique case (r_phase)
                PH_TAG: begin
                    n_tag   = i_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    n_left  = i_byte;
                    n_shift = '0;
                    if (i_byte == 8'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = PH_VAL;
                    end
                end
                PH_VAL: begin
                    // only the first four value bytes land in the word
                    if (idx[7:2] == 6'd0) begin
                        n_shift = r_shift | ({24'd0, i_byte} << {idx[1:0], 3'b000});
                    end
                    n_left = r_left - 8'd1;
                    if (n_left == 8'd0) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase
        end
        if (finish) begin
            n_phase = PH_TAG;
            if (n_tag == TAG_LINEAR && n_len == LEN_WORD) begin
                n_pend.linear           = n_shift;
                n_pend.found[F_LINEAR]  = 1'b1;
            end else if (n_tag == TAG_ANGULAR && n_len == LEN_WORD) begin
                n_pend.angular          = n_shift;
                n_pend.found[F_ANGULAR] = 1'b1;
            end else if (n_tag == TAG_LIFT && n_len == LEN_WORD) begin
                n_pend.lift             = n_shift;
                n_pend.found[F_LIFT]    = 1'b1;
            end else if (n_tag == TAG_MASK && n_len == LEN_HALF) begin
                n_pend.mask             = n_shift[15:0];
                n_pend.found[F_MASK]    = 1'b1;
            end else if (n_tag == TAG_STATUS && n_len == LEN_HALF) begin
                n_pend.status           = n_shift[15:0];
                n_pend.found[F_STATUS]  = 1'b1;
            end
        end
    end

    assign o_pend = n_pend;

    // phase and collected values, cleared at every frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_pend  <= '0;
        end else if (i_frame_end) begin
            r_phase <= PH_TAG;
            r_pend  <= '0;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

    // record state, only read after it has been written in the same record
    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_len   <= n_len;
        r_left  <= n_left;
        r_shift <= n_shift;
    end

endmodule
